// ===== rtl/core/sidiv_pkg.sv =====
// Package for the signed saturating divider: controller state type.
`timescale 1ns / 1ps

package sidiv_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

// ===== rtl/core/signed_int_divider_saturating.sv =====
// Signed saturating integer divider, radix-2 restoring, one quotient bit per cycle.
`timescale 1ns / 1ps

// Divides a signed DATA_WIDTH-bit dividend by a signed divisor and returns the
// quotient truncated toward zero. The most negative value divided by minus one
// gives the largest positive value. A zero divisor gives the largest positive
// value with tuser (divide-by-zero) set. The operand magnitudes are loaded at
// acceptance; the divider then steps DATA_WIDTH times through the single shared
// subtract-and-compare stage, one quotient bit per cycle, and applies sign fix-up
// and saturation in the output state, which waits while an earlier result is
// still unread. A finished result waits in the output register, so the next item
// is taken while it is still waiting to be read.
module signed_int_divider_saturating #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // dividend, divisor
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // quotient
    output logic [((DATA_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
    // divide_by_zero
    output logic                                   m_axis_tuser
);

    localparam int W      = DATA_WIDTH;
    localparam int CNT_W  = $clog2(DATA_WIDTH);
    localparam int OUT_DW = ((DATA_WIDTH+7)/8)*8;
    localparam logic [W-1:0]     MAX_POS  = {1'b0, {(W-1){1'b1}}};
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH-1);

    sidiv_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [W-1:0]     r_num, n_num;
    logic [W-1:0]     r_den, n_den;
    logic [W-1:0]     r_rem, n_rem;
    logic             r_neg, n_neg;
    logic             r_dbz, n_dbz;
    logic             r_out_valid, n_out_valid;
    logic [W-1:0]     r_out_q, n_out_q;
    logic             r_out_dbz, n_out_dbz;

    logic [W-1:0] in_a, in_b;
    logic [W-1:0] mag_a, mag_b;
    logic [W-1:0] rem_sh;
    logic [W:0]   diff;
    logic         ge;
    logic [W-1:0] q_final;
    logic         in_acc;
    logic         out_load;

    assign in_a   = s_axis_tdata[W-1:0];
    assign in_b   = s_axis_tdata[2*W-1:W];
    assign mag_a  = in_a[W-1] ? (~in_a + 1'b1) : in_a;
    assign mag_b  = in_b[W-1] ? (~in_b + 1'b1) : in_b;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Restoring step: bring down next dividend bit, trial subtract.
    assign rem_sh = {r_rem[W-2:0], r_num[W-1]};
    assign diff   = {1'b0, rem_sh} - {1'b0, r_den};
    assign ge     = !diff[W];

    always_comb begin
        if (r_dbz) begin
            q_final = MAX_POS;
        end else if (r_neg) begin
            q_final = ~r_num + 1'b1;
        end else if (r_num[W-1]) begin
            q_final = MAX_POS;
        end else begin
            q_final = r_num;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sidiv_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = sidiv_pkg::ST_DIV;
                end
            end
            sidiv_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = sidiv_pkg::ST_OUT;
                end
            end
            sidiv_pkg::ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = sidiv_pkg::ST_IDLE;
                end
            end
            default: n_state = sidiv_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        n_cnt         = r_cnt;
        n_num         = r_num;
        n_den         = r_den;
        n_rem         = r_rem;
        n_neg         = r_neg;
        n_dbz         = r_dbz;
        case (r_state)
            sidiv_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (in_acc) begin
                    n_cnt = CNT_LAST;
                    n_num = mag_a;
                    n_den = mag_b;
                    n_rem = '0;
                    n_neg = in_a[W-1] ^ in_b[W-1];
                    n_dbz = (in_b == '0);
                end
            end
            sidiv_pkg::ST_DIV: begin
                n_cnt = r_cnt - 1'b1;
                n_num = {r_num[W-2:0], ge};
                n_rem = ge ? diff[W-1:0] : rem_sh;
            end
            sidiv_pkg::ST_OUT: begin
                out_load = !r_out_valid || m_axis_tready;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_q     = r_out_q;
        n_out_dbz   = r_out_dbz;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_q     = q_final;
            n_out_dbz   = r_dbz;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sidiv_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num     <= n_num;
        r_den     <= n_den;
        r_rem     <= n_rem;
        r_neg     <= n_neg;
        r_dbz     <= n_dbz;
        r_out_q   <= n_out_q;
        r_out_dbz <= n_out_dbz;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DW'(r_out_q);
    assign m_axis_tuser  = r_out_dbz;

    a_load_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == sidiv_pkg::ST_DIV) && (r_cnt == CNT_LAST))
        else $error("divide did not start after accept");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sidiv_pkg::ST_DIV) && (r_cnt == '0) |=> r_state == sidiv_pkg::ST_OUT)
        else $error("divide did not finish after last step");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sidiv_pkg::ST_DIV) && !r_dbz |-> r_rem < r_den)
        else $error("partial remainder not below divisor");

    a_dbz_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_dbz |-> r_out_q == MAX_POS)
        else $error("divide by zero result not saturated");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> $stable(r_out_q))
        else $error("waiting result overwritten");

endmodule

// ===== bench/quotient_checker.sv =====
// Checker for the signed saturating divider: predicts each quotient and compares results.
`timescale 1ns / 1ps

module quotient_checker #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_ready,
    // dividend, divisor
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      i_in_data,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_ready,
    // quotient
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]        i_out_data,
    // divide_by_zero
    input  logic                                   i_out_user,
    output int                                     o_errors,
    output int                                     o_pending
);

    localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    typedef struct packed {
        logic [DATA_WIDTH-1:0] quotient;
        logic                  div_zero;
    } t_quot;

    t_quot quot_expected[$];

    function automatic t_quot predict_quotient(logic [DATA_WIDTH-1:0] num,
                                               logic [DATA_WIDTH-1:0] den);
        logic                  neg_n;
        logic                  neg_d;
        logic [DATA_WIDTH-1:0] mag_n;
        logic [DATA_WIDTH-1:0] mag_d;
        logic [DATA_WIDTH-1:0] quo;
        logic [DATA_WIDTH:0]   rem;
        t_quot                 res;
        neg_n = num[DATA_WIDTH-1];
        neg_d = den[DATA_WIDTH-1];
        mag_n = neg_n ? -num : num;
        mag_d = neg_d ? -den : den;
        if (mag_d == '0) begin
            res.quotient = MAX_POS;
            res.div_zero = 1'b1;
            return res;
        end
        rem = '0;
        quo = '0;
        for (int i = DATA_WIDTH - 1; i >= 0; i--) begin
            rem = {rem[DATA_WIDTH-1:0], mag_n[i]};
            if (rem >= {1'b0, mag_d}) begin
                rem = rem - {1'b0, mag_d};
                quo[i] = 1'b1;
            end
        end
        if (neg_n != neg_d) begin
            res.quotient = -quo;
        end else if (quo > MAX_POS) begin
            res.quotient = MAX_POS;
        end else begin
            res.quotient = quo;
        end
        res.div_zero = 1'b0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_quot want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (quot_expected.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result: quotient %0d dbz %0b",
                                 $signed(i_out_data[DATA_WIDTH-1:0]), i_out_user);
                    o_errors <= o_errors + 1;
                end else begin
                    want = quot_expected.pop_front();
                    if (i_out_data[DATA_WIDTH-1:0] !== want.quotient ||
                        i_out_user !== want.div_zero) begin
                        if (o_errors < 10)
                            $display("mismatch: quotient exp %0d got %0d, dbz exp %0b got %0b",
                                     $signed(want.quotient),
                                     $signed(i_out_data[DATA_WIDTH-1:0]),
                                     want.div_zero, i_out_user);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                quot_expected.push_back(predict_quotient(i_in_data[DATA_WIDTH-1:0],
                                        i_in_data[2*DATA_WIDTH-1:DATA_WIDTH]));
            o_pending <= quot_expected.size();
        end
    end

endmodule

// ===== bench/signed_int_divider_saturating_tb.sv =====
// Testbench top for the signed saturating divider: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module signed_int_divider_saturating_tb;

    localparam int          W         = 32;
    localparam int          LIMIT     = 750000;
    localparam int          N_RANDOM  = 1250;
    localparam logic [31:0] MIN_V     = 32'h8000_0000;
    localparam logic [31:0] MAX_V     = 32'h7fff_ffff;
    localparam logic [31:0] NEG1      = 32'hffff_ffff;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [63:0]   s_axis_tdata;    // dividend, divisor
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [31:0]   m_axis_tdata;    // quotient
    logic          m_axis_tuser;    // divide_by_zero

    int            errors;
    int            pending;
    int            items_sent;
    int            cycle_count;

    signed_int_divider_saturating #(
        .DATA_WIDTH(W)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    quotient_checker #(
        .DATA_WIDTH(W)
    ) checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_division(input logic [31:0] dividend, input logic [31:0] divisor);
        int gap;
        s_axis_tdata  <= {divisor, dividend};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        if ($urandom_range(0, 9) == 0)
            gap = $urandom_range(5, 40);
        else if ($urandom_range(0, 1) == 0)
            gap = 0;
        else
            gap = $urandom_range(1, 3);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_operand();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4:          v = $urandom_range(0, 40) - 20;
            5: begin
                case ($urandom_range(0, 4))
                    0: v = MIN_V;
                    1: v = MAX_V;
                    2: v = NEG1;
                    3: v = 32'd1;
                    default: v = '0;
                endcase
            end
            6: begin
                v = 32'd1 << $urandom_range(0, 31);
                if ($urandom_range(0, 1)) v = -v;
            end
            default: v = $signed($urandom) >>> $urandom_range(0, 31);
        endcase
        return v;
    endfunction

    // flow control on the result side, with one long hold-off to back up the input
    initial begin
        logic held;
        held = 1'b0;
        m_axis_tready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!held && items_sent >= 30) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else begin
                case ($urandom_range(0, 19))
                    0: begin
                        m_axis_tready <= 1'b0;
                        repeat ($urandom_range(10, 60)) @(posedge i_clk);
                    end
                    1: begin
                        m_axis_tready <= 1'b1;
                        repeat ($urandom_range(50, 200)) @(posedge i_clk);
                    end
                    default: begin
                        m_axis_tready <= ($urandom_range(0, 3) != 0);
                        @(posedge i_clk);
                    end
                endcase
            end
        end
    end

    initial begin
        items_sent = 0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_rst_n       <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // edge cases: zero divisor, overflow, most negative result, signs
        send_division(32'd0, 32'd1);
        send_division(32'd1, 32'd0);
        send_division(32'd0, 32'd0);
        send_division(MIN_V, 32'd0);
        send_division(MAX_V, 32'd0);
        send_division(NEG1, 32'd0);
        send_division(MIN_V, NEG1);
        send_division(MIN_V, 32'd1);
        send_division(MIN_V, MIN_V);
        send_division(MAX_V, MIN_V);
        send_division(MAX_V, NEG1);
        send_division(MAX_V, MAX_V);
        send_division(MIN_V, MAX_V);
        send_division(MIN_V, 32'd2);
        send_division(NEG1, NEG1);
        send_division(-32'sd7, 32'd2);
        send_division(32'd7, -32'sd2);
        send_division(-32'sd7, -32'sd2);
        send_division(32'd7, 32'd2);
        send_division(32'd1, MAX_V);
        send_division(32'd100, 32'd7);
        send_division(-32'sd100, 32'd7);

        for (int n = 0; n < N_RANDOM; n++)
            send_division(rand_operand(), rand_operand());
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
